// File: hw/rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and fixed widths of the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int AVG_W        = 24;
  localparam int COUNT_W      = 7;
  localparam int OUT_TDATA_W  = 32;
  localparam int WINDOW_RESET = 10;

  typedef struct packed {
    logic capture;
    logic update;
    logic load;
    logic step;
    logic out_load;
  } swa_cmd_t;

  typedef struct packed {
    logic div_last;
  } swa_status_t;

endpackage

// File: hw/rtl/swa_ram.sv
// ----------------------------------------------------------------------------
// swa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/swa_datapath.sv
// ----------------------------------------------------------------------------
// swa_datapath
// Sample ring, fill count, running sum, restoring divider and output register.
// ----------------------------------------------------------------------------
module swa_datapath #(
  parameter int MAX_WINDOW    = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            window_size_wr_en,
  input  logic [swa_pkg::COUNT_W-1:0]     window_size_wr_data,
  input  logic [swa_pkg::SAMPLE_W-1:0]    sample_in,
  input  swa_pkg::swa_cmd_t               cmd,
  output swa_pkg::swa_status_t            status,
  output logic [swa_pkg::OUT_TDATA_W-1:0] result
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = swa_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int DIV_W  = SUM_W + FRACTION_BITS;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int CMP_W  = ((ADDR_W > swa_pkg::COUNT_W) ? ADDR_W : swa_pkg::COUNT_W) + 1;
  localparam int CW     = swa_pkg::COUNT_W;

  function automatic logic [CW-1:0] effective_window(input logic [CW-1:0] value);
    logic [CW-1:0] w;
    if (value == '0) begin
      w = CW'(1);
    end else if (int'(value) > MAX_WINDOW) begin
      w = CW'(MAX_WINDOW);
    end else begin
      w = value;
    end
    return w;
  endfunction

  logic [CW-1:0]                      window;
  logic [ADDR_W-1:0]                  pos;
  logic [CW-1:0]                      fill;
  logic signed [SUM_W-1:0]            sum;
  logic signed [swa_pkg::SAMPLE_W-1:0] sample;
  logic [swa_pkg::SAMPLE_W-1:0]       old_sample;
  logic                               full;
  logic signed [SUM_W-1:0]            sum_next;
  logic [ADDR_W-1:0]                  pos_next;
  logic [SUM_W-1:0]                   magnitude;
  logic [DIV_W-1:0]                   quo;
  logic [CW:0]                        rem;
  logic [CW:0]                        trial;
  logic                               negative;
  logic [STEP_W-1:0]                  step_cnt;
  logic [swa_pkg::AVG_W-1:0]          quo_avg;
  logic [swa_pkg::AVG_W-1:0]          average;
  logic [CW-1:0]                      count_out;

  swa_ram #(
    .WIDTH(swa_pkg::SAMPLE_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(pos),
    .wdata(sample),
    .raddr(pos),
    .rdata(old_sample)
  );

  assign full     = (fill == window);
  assign sum_next = sum + SUM_W'(sample)
                    - (full ? SUM_W'($signed(old_sample)) : SUM_W'(0));
  assign pos_next = ((CMP_W'(pos) + CMP_W'(1)) >= CMP_W'(window)) ? '0 : pos + ADDR_W'(1);
  assign magnitude = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign trial     = {rem[CW-1:0], quo[DIV_W-1]};
  assign quo_avg   = swa_pkg::AVG_W'(quo);
  assign status.div_last = (step_cnt == STEP_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= effective_window(CW'(swa_pkg::WINDOW_RESET));
      pos    <= '0;
      fill   <= '0;
      sum    <= '0;
    end else if (window_size_wr_en) begin
      window <= effective_window(window_size_wr_data);
      pos    <= '0;
      fill   <= '0;
      sum    <= '0;
    end else if (cmd.update) begin
      pos  <= pos_next;
      fill <= full ? fill : fill + CW'(1);
      sum  <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= $signed(sample_in);
    end
    if (cmd.load) begin
      quo      <= DIV_W'(magnitude) << FRACTION_BITS;
      rem      <= '0;
      negative <= sum[SUM_W-1];
      step_cnt <= '0;
    end else if (cmd.step) begin
      if (trial >= {1'b0, fill}) begin
        rem <= trial - {1'b0, fill};
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
      step_cnt <= step_cnt + STEP_W'(1);
    end
    if (cmd.out_load) begin
      average   <= negative ? -quo_avg : quo_avg;
      count_out <= fill;
    end
  end

  assign result = {{(swa_pkg::OUT_TDATA_W - swa_pkg::AVG_W - CW){1'b0}}, count_out, average};

endmodule

// File: hw/rtl/swa_ctrl.sv
// ----------------------------------------------------------------------------
// swa_ctrl
// Sequencer for one sample: accept, update, divider load, division, hand-off.
// ----------------------------------------------------------------------------
module swa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  swa_pkg::swa_status_t status,
  output swa_pkg::swa_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPDATE = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_DIVIDE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average
// Moving average over the most recent signed 16-bit samples.
// ----------------------------------------------------------------------------
// Each sample taken on the slave stream yields one transaction on the master
// stream carrying the mean of the samples now in the window, in signed fixed
// point with FRACTION_BITS fractional bits and truncated toward zero, together
// with the number of samples it was taken over. Until the window has filled,
// the mean covers every sample seen since the last clear.
// The window length is set through the write port; a value of zero acts as
// one, a value above MAX_WINDOW as MAX_WINDOW. Writing it also clears the
// store, and it should only be written while the block is idle.
// One sample is processed at a time. The running sum is updated in the cycle
// after acceptance and then divided by the fill count in a restoring divider
// that yields one quotient bit per cycle, SUM_W + FRACTION_BITS bits in all
// (30 with the default parameters). The result is loaded into the output
// register once the division is done and the register is free, and the next
// sample can be taken the cycle after the result reaches the output register.
// The output register holds a result while the receiver stalls, so a new
// sample can be taken meanwhile; the next result waits until it is free.
// Reset restores a window of 10 and an empty store; no sample is taken while
// reset is held.
// ----------------------------------------------------------------------------
module sliding_window_average #(
  parameter int MAX_WINDOW    = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            window_size_wr_en,
  input  logic [swa_pkg::COUNT_W-1:0]     window_size_wr_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [swa_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [swa_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [23:0] average, [30:24] samples_in_window
);

  swa_pkg::swa_cmd_t    cmd;
  swa_pkg::swa_status_t status;

  swa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .status       (status),
    .cmd          (cmd)
  );

  swa_datapath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .window_size_wr_en  (window_size_wr_en),
    .window_size_wr_data(window_size_wr_data),
    .sample_in          (s_axis_tdata),
    .cmd                (cmd),
    .status             (status),
    .result             (m_axis_tdata)
  );

endmodule
